@@ hdl/fpe_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpe_pkg
// Types, register indexes and helper functions for the frustum plane
// extraction pipeline.
// ----------------------------------------------------------------------------
package fpe_pkg;

    localparam int unsigned VAL_W   = 32;
    localparam int unsigned PROD_W  = 64;
    localparam int unsigned RND_W   = 48;
    localparam int unsigned CLIP_W  = 49;
    localparam int unsigned PLANE_W = 50;
    localparam int unsigned COL_W   = 2;
    localparam int unsigned IDX_W   = 3;

    localparam logic [COL_W-1:0] COL_WCOMP = 2'd3;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_PROJ_XX = 3'd0;
    localparam logic [IDX_W-1:0] REG_PROJ_YY = 3'd1;
    localparam logic [IDX_W-1:0] REG_PROJ_ZX = 3'd2;
    localparam logic [IDX_W-1:0] REG_PROJ_ZY = 3'd3;
    localparam logic [IDX_W-1:0] REG_PROJ_ZZ = 3'd4;
    localparam logic [IDX_W-1:0] REG_PROJ_ZW = 3'd5;
    localparam logic [IDX_W-1:0] REG_PROJ_WZ = 3'd6;

    localparam logic [VAL_W-1:0] Q16_ONE  = 32'h0001_0000;
    localparam logic [VAL_W-1:0] Q16_ZERO = 32'h0000_0000;

    typedef struct packed {
        logic signed [VAL_W-1:0] xx;
        logic signed [VAL_W-1:0] yy;
        logic signed [VAL_W-1:0] zx;
        logic signed [VAL_W-1:0] zy;
        logic signed [VAL_W-1:0] zz;
        logic signed [VAL_W-1:0] zw;
        logic signed [VAL_W-1:0] wz;
    } proj_t;

    typedef struct packed {
        logic [COL_W-1:0]         col;
        logic signed [VAL_W-1:0]  x;
        logic signed [VAL_W-1:0]  y;
        logic signed [VAL_W-1:0]  z;
        logic signed [VAL_W-1:0]  w;
    } view_t;

    typedef struct packed {
        logic [COL_W-1:0]         col;
        logic signed [PROD_W-1:0] xx;
        logic signed [PROD_W-1:0] zx;
        logic signed [PROD_W-1:0] yy;
        logic signed [PROD_W-1:0] zy;
        logic signed [PROD_W-1:0] zz;
        logic signed [PROD_W-1:0] zw;
        logic signed [PROD_W-1:0] wz;
    } prod_t;

    typedef struct packed {
        logic [COL_W-1:0]        col;
        logic signed [RND_W-1:0] xx;
        logic signed [RND_W-1:0] zx;
        logic signed [RND_W-1:0] yy;
        logic signed [RND_W-1:0] zy;
        logic signed [RND_W-1:0] zz;
        logic signed [RND_W-1:0] zw;
        logic signed [RND_W-1:0] wz;
    } rnd_t;

    typedef struct packed {
        logic [COL_W-1:0]         col;
        logic signed [CLIP_W-1:0] c0;
        logic signed [CLIP_W-1:0] c1;
        logic signed [CLIP_W-1:0] c2;
        logic signed [CLIP_W-1:0] c3;
    } clip_t;

    typedef struct packed {
        logic [COL_W-1:0]        col;
        logic signed [VAL_W-1:0] left;
        logic signed [VAL_W-1:0] right;
        logic signed [VAL_W-1:0] bottom;
        logic signed [VAL_W-1:0] top;
        logic signed [VAL_W-1:0] near;
        logic signed [VAL_W-1:0] far;
    } plane_t;

    // Q32.32 product to Q16.16, rounding half up.
    function automatic logic signed [RND_W-1:0] round_q16(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] t;
        begin
            t = p + 64'sd32768;
            return t[PROD_W-1:PROD_W-RND_W];
        end
    endfunction

    // Clamp to the signed 32-bit range: in range when all upper bits match the sign.
    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [PLANE_W-1:0] v);
        logic [PLANE_W-VAL_W:0] hi;
        begin
            hi = v[PLANE_W-1:VAL_W-1];
            if ((&hi) || !(|hi)) begin
                return v[VAL_W-1:0];
            end else if (v[PLANE_W-1]) begin
                return 32'sh8000_0000;
            end else begin
                return 32'sh7FFF_FFFF;
            end
        end
    endfunction

endpackage
`default_nettype wire

@@ hdl/fpe_cfg_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpe_cfg_regs
// Projection matrix entries, written through the configuration channel.
// ----------------------------------------------------------------------------
module fpe_cfg_regs
    import fpe_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [IDX_W-1:0] cfg_index,
    input  wire logic [VAL_W-1:0] cfg_data,
    output proj_t                 proj
);

    proj_t proj_reg;
    proj_t proj_next;

    assign cfg_ready = 1'b1;
    assign proj      = proj_reg;

    always_comb begin
        proj_next = proj_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_PROJ_XX: proj_next.xx = cfg_data;
                REG_PROJ_YY: proj_next.yy = cfg_data;
                REG_PROJ_ZX: proj_next.zx = cfg_data;
                REG_PROJ_ZY: proj_next.zy = cfg_data;
                REG_PROJ_ZZ: proj_next.zz = cfg_data;
                REG_PROJ_ZW: proj_next.zw = cfg_data;
                REG_PROJ_WZ: proj_next.wz = cfg_data;
                default: ;  // Writes past the last register are dropped.
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            proj_reg.xx <= Q16_ONE;
            proj_reg.yy <= Q16_ONE;
            proj_reg.zx <= Q16_ZERO;
            proj_reg.zy <= Q16_ZERO;
            proj_reg.zz <= Q16_ONE;
            proj_reg.zw <= Q16_ZERO;
            proj_reg.wz <= Q16_ZERO;
        end else begin
            proj_reg <= proj_next;
        end
    end

endmodule
`default_nettype wire

@@ hdl/fpe_mul_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpe_mul_stage
// First stage: the seven exact Q32.32 products of view and projection entries.
// ----------------------------------------------------------------------------
module fpe_mul_stage
    import fpe_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  view_t      in_data,
    input  proj_t      proj,
    output logic       out_valid,
    input  wire logic  out_ready,
    output prod_t      out_data
);

    logic  valid_reg;
    prod_t data_reg;
    prod_t data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        data_next.col = in_data.col;
        data_next.xx  = $signed(in_data.x) * $signed(proj.xx);
        data_next.zx  = $signed(in_data.z) * $signed(proj.zx);
        data_next.yy  = $signed(in_data.y) * $signed(proj.yy);
        data_next.zy  = $signed(in_data.z) * $signed(proj.zy);
        data_next.zz  = $signed(in_data.z) * $signed(proj.zz);
        data_next.zw  = $signed(in_data.z) * $signed(proj.zw);
        data_next.wz  = $signed(in_data.w) * $signed(proj.wz);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule
`default_nettype wire

@@ hdl/fpe_round_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpe_round_stage
// Second stage: rounds every product half up to Q16.16 at full width.
// ----------------------------------------------------------------------------
module fpe_round_stage
    import fpe_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  prod_t      in_data,
    output logic       out_valid,
    input  wire logic  out_ready,
    output rnd_t       out_data
);

    logic valid_reg;
    rnd_t data_reg;
    rnd_t data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        data_next.col = in_data.col;
        data_next.xx  = round_q16(in_data.xx);
        data_next.zx  = round_q16(in_data.zx);
        data_next.yy  = round_q16(in_data.yy);
        data_next.zy  = round_q16(in_data.zy);
        data_next.zz  = round_q16(in_data.zz);
        data_next.zw  = round_q16(in_data.zw);
        data_next.wz  = round_q16(in_data.wz);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule
`default_nettype wire

@@ hdl/fpe_clip_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpe_clip_stage
// Third stage: forms the clip matrix column c0..c3 without saturation.
// ----------------------------------------------------------------------------
module fpe_clip_stage
    import fpe_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  rnd_t       in_data,
    output logic       out_valid,
    input  wire logic  out_ready,
    output clip_t      out_data
);

    logic  valid_reg;
    clip_t data_reg;
    clip_t data_next;
    logic signed [RND_W-1:0] wz_term;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // The w entry only takes part in the w column.
    assign wz_term = (in_data.col == COL_WCOMP) ? $signed(in_data.wz) : '0;

    always_comb begin
        data_next.col = in_data.col;
        data_next.c0  = CLIP_W'($signed(in_data.xx)) + CLIP_W'($signed(in_data.zx));
        data_next.c1  = CLIP_W'($signed(in_data.yy)) + CLIP_W'($signed(in_data.zy));
        data_next.c2  = CLIP_W'($signed(in_data.zz)) + CLIP_W'(wz_term);
        data_next.c3  = CLIP_W'($signed(in_data.zw));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule
`default_nettype wire

@@ hdl/fpe_plane_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpe_plane_stage
// Last stage and output register: six plane components, each saturated.
// ----------------------------------------------------------------------------
module fpe_plane_stage
    import fpe_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  clip_t      in_data,
    output logic       out_valid,
    input  wire logic  out_ready,
    output plane_t     out_data
);

    logic   valid_reg;
    plane_t data_reg;
    plane_t data_next;
    logic signed [PLANE_W-1:0] c0;
    logic signed [PLANE_W-1:0] c1;
    logic signed [PLANE_W-1:0] c2;
    logic signed [PLANE_W-1:0] c3;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    assign c0 = PLANE_W'($signed(in_data.c0));
    assign c1 = PLANE_W'($signed(in_data.c1));
    assign c2 = PLANE_W'($signed(in_data.c2));
    assign c3 = PLANE_W'($signed(in_data.c3));

    always_comb begin
        data_next.col    = in_data.col;
        data_next.left   = sat32(c3 + c0);
        data_next.right  = sat32(c3 - c0);
        data_next.bottom = sat32(c3 + c1);
        data_next.top    = sat32(c3 - c1);
        data_next.near   = sat32(c3 + c2);
        data_next.far    = sat32(c3 - c2);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule
`default_nettype wire

@@ hdl/frustum_plane_extract_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one item per cycle while the output is not stalled; four
// register stages (multiply, round, clip column sum, plane sum with
// saturation), each with its own valid bit.
// A stalled output holds only the stages that have no free slot behind them.
// Reset clears all valid bits and loads the identity-like projection values.
// ----------------------------------------------------------------------------
// frustum_plane_extract_unit
// Frustum plane components from one view matrix column per item.
// ----------------------------------------------------------------------------
module frustum_plane_extract_unit
    import fpe_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    // column_index [1:0], view_x [33:2], view_y [65:34], view_z [97:66],
    // view_w [129:98], zero padding [135:130]
    input  wire logic [135:0]     s_tdata,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    // component_index [1:0], left_comp [33:2], right_comp [65:34],
    // bottom_comp [97:66], top_comp [129:98], near_comp [161:130],
    // far_comp [193:162], zero padding [199:194]
    output logic [199:0]          m_tdata,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [IDX_W-1:0] cfg_index,
    input  wire logic [VAL_W-1:0] cfg_data
);

    proj_t  proj;
    view_t  view;
    prod_t  prod;
    rnd_t   rnd;
    clip_t  clip;
    plane_t plane;
    logic   prod_valid;
    logic   prod_ready;
    logic   rnd_valid;
    logic   rnd_ready;
    logic   clip_valid;
    logic   clip_ready;

    assign view.col = s_tdata[1:0];
    assign view.x   = s_tdata[33:2];
    assign view.y   = s_tdata[65:34];
    assign view.z   = s_tdata[97:66];
    assign view.w   = s_tdata[129:98];

    fpe_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .proj      (proj)
    );

    fpe_mul_stage u_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (view),
        .proj      (proj),
        .out_valid (prod_valid),
        .out_ready (prod_ready),
        .out_data  (prod)
    );

    fpe_round_stage u_rnd (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (prod_valid),
        .in_ready  (prod_ready),
        .in_data   (prod),
        .out_valid (rnd_valid),
        .out_ready (rnd_ready),
        .out_data  (rnd)
    );

    fpe_clip_stage u_clip (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (rnd_valid),
        .in_ready  (rnd_ready),
        .in_data   (rnd),
        .out_valid (clip_valid),
        .out_ready (clip_ready),
        .out_data  (clip)
    );

    fpe_plane_stage u_plane (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (clip_valid),
        .in_ready  (clip_ready),
        .in_data   (clip),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (plane)
    );

    assign m_tdata = {6'b0, plane.far, plane.near, plane.top, plane.bottom,
                      plane.right, plane.left, plane.col};

endmodule
`default_nettype wire

@@ hdl/fpe_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpe_checker
// Port-level checks on the frustum plane extraction unit.
// ----------------------------------------------------------------------------
module fpe_checker (
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             s_tvalid,
    input wire logic             s_tready,
    input wire logic             m_tvalid,
    input wire logic             m_tready,
    input wire logic [199:0]     m_tdata
);

    // A result waiting on the output keeps its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output item changed while stalled");

    // The pipeline only pushes back when every stage is full and the output is stalled.
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled with room in the pipeline");

    // A result appearing on an empty output is an item accepted at the input, registered through every stage.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 4))
        else $error("result without an item four cycles earlier");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

endmodule

bind frustum_plane_extract_unit fpe_checker u_fpe_checker (.*);
`default_nettype wire
